[hw/rtl/idet_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the integer determinant engine.
// No dependencies; imported by every module of the block.
package idet_pkg;
   localparam int MAX_ORDER  = 8;
   localparam int ORDER_W    = 4;
   localparam int IDX_W      = 3;                  // row or column index
   localparam int ADDR_W     = 2 * IDX_W;          // matrix store address
   localparam int SUB_W      = MAX_ORDER;          // column subset mask
   localparam int ELEM_W     = 8;
   localparam int ACC_W      = 72;
   localparam int DET_W      = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = 2;
   localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd5;

   typedef struct packed {
      logic [ELEM_W-1:0]  elem;
      logic [ADDR_W-1:0]  addr;
      logic               last;
      logic [ORDER_W-1:0] order;
   } entry_type;

   typedef enum logic [2:0] {
      B_LOAD, B_INIT, B_SCAN, B_MUL, B_ADD, B_STORE, B_DONE
   } back_state_type;
endpackage

[hw/rtl/idet_front.sv]
`timescale 1ns / 1ps
// Front end: order register, request intake, row/column tracking.
// Depends on idet_pkg.
module idet_front import idet_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [ORDER_W-1:0]   csr_data,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ELEM_W-1:0]    req_tdata,
   output logic                 push,
   output entry_type            push_entry,
   input  logic                 queue_full
);
   logic [ORDER_W-1:0] order_ff, order_in;
   logic [IDX_W-1:0]   row_ff, row_in, col_ff, col_in;
   logic [ORDER_W-1:0] last_idx;
   logic               at_row_end;

   assign csr_ready  = 1'b1;
   // hold requests off while the order is being written
   assign req_tready = ~queue_full & ~csr_valid;
   assign push       = req_tvalid & req_tready;
   assign last_idx   = order_ff - 4'd1;
   assign at_row_end = ({1'b0, col_ff} == last_idx);

   assign push_entry.elem  = req_tdata;
   assign push_entry.addr  = {row_ff, col_ff};
   assign push_entry.last  = at_row_end & ({1'b0, row_ff} == last_idx);
   assign push_entry.order = order_ff;

   always_comb begin
      order_in = order_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      if (csr_valid) begin
         // clamp to 1..MAX_ORDER and drop any partial load
         if (csr_data == '0) order_in = 4'd1;
         else if (csr_data > ORDER_W'(MAX_ORDER)) order_in = ORDER_W'(MAX_ORDER);
         else order_in = csr_data;
         row_in = '0;
         col_in = '0;
      end else if (push) begin
         if (push_entry.last) begin
            row_in = '0;
            col_in = '0;
         end else if (at_row_end) begin
            row_in = row_ff + 3'd1;
            col_in = '0;
         end else begin
            col_in = col_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         order_ff <= order_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end
endmodule

[hw/rtl/idet_queue.sv]
`timescale 1ns / 1ps
// Short request queue between front and back end.
// Depends on idet_pkg.
module idet_queue import idet_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      pop_valid,
   output entry_type pop_entry
);
   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_pop;

   assign full      = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_entry = slot_ff[rd_ff];
   assign do_pop    = pop & pop_valid;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

[hw/rtl/idet_back.sv]
`timescale 1ns / 1ps
// Back end: matrix store, minor-expansion sequencer over column subsets,
// saturation and result register. Depends on idet_pkg.
module idet_back import idet_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   input  entry_type        pop_entry,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [DET_W-1:0] rsp_tdata,
   output logic             rsp_tuser
);
   back_state_type state_ff, state_in;
   logic [ORDER_W-1:0]   n_ff, n_in, j_ff, j_in, pos_ff, pos_in;
   logic [SUB_W-1:0]     full_ff, full_in, s_ff, s_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, prod_ff, prod_in;
   logic                 neg_ff, neg_in;
   logic                 rv_ff, rv_in, ovf_ff, ovf_in;
   logic [DET_W-1:0]     det_ff, det_in;

   logic [ELEM_W-1:0]    mat_mem [1 << ADDR_W];
   logic [ELEM_W-1:0]    mat_rd_ff;
   logic signed [ACC_W-1:0] work_mem [1 << SUB_W];
   logic signed [ACC_W-1:0] work_rd_ff;

   logic                 mat_we, work_we;
   logic [ADDR_W-1:0]    mat_raddr;
   logic [SUB_W-1:0]     work_waddr, work_raddr;
   logic signed [ACC_W-1:0] work_wdata;
   logic [ORDER_W-1:0]   kcnt;
   logic [IDX_W-1:0]     row;
   logic signed [ACC_W+ELEM_W-1:0] prod_full;
   logic                 fits;

   assign kcnt      = ORDER_W'($countones(s_ff));
   assign row       = IDX_W'(kcnt - 4'd1);
   assign prod_full = $signed(mat_rd_ff) * work_rd_ff;
   assign fits      = (acc_ff[ACC_W-1:DET_W-1] == '0) || (acc_ff[ACC_W-1:DET_W-1] == '1);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = det_ff;
   assign rsp_tuser  = ovf_ff;

   always_comb begin
      state_in = state_ff;
      n_in = n_ff; j_in = j_ff; pos_in = pos_ff;
      full_in = full_ff; s_in = s_ff;
      acc_in = acc_ff; prod_in = prod_ff; neg_in = neg_ff;
      rv_in = rv_ff & ~rsp_tready;
      det_in = det_ff; ovf_in = ovf_ff;
      pop = 1'b0;
      mat_we = 1'b0; work_we = 1'b0;
      mat_raddr = {row, j_ff[IDX_W-1:0]};
      work_raddr = s_ff & ~(SUB_W'(1) << j_ff[IDX_W-1:0]);
      work_waddr = s_ff;
      work_wdata = acc_ff;
      case (state_ff)
         B_LOAD: begin
            pop = 1'b1;
            if (pop_valid) begin
               mat_we = 1'b1;
               if (pop_entry.last) begin
                  n_in     = pop_entry.order;
                  full_in  = SUB_W'((9'd1 << pop_entry.order) - 9'd1);
                  state_in = B_INIT;
               end
            end
         end
         B_INIT: begin
            // empty subset has minor one
            work_we    = 1'b1;
            work_waddr = '0;
            work_wdata = ACC_W'(1);
            s_in = SUB_W'(1); j_in = '0; pos_in = '0; acc_in = '0;
            state_in = B_SCAN;
         end
         B_SCAN: begin
            if (j_ff == n_ff) state_in = B_STORE;
            else if (s_ff[j_ff[IDX_W-1:0]]) state_in = B_MUL;
            else j_in = j_ff + 4'd1;
         end
         B_MUL: begin
            prod_in  = prod_full[ACC_W-1:0];
            neg_in   = ~(kcnt[0] ^ pos_ff[0]);
            state_in = B_ADD;
         end
         B_ADD: begin
            acc_in   = neg_ff ? acc_ff - prod_ff : acc_ff + prod_ff;
            j_in     = j_ff + 4'd1;
            pos_in   = pos_ff + 4'd1;
            state_in = B_SCAN;
         end
         B_STORE: begin
            work_we = 1'b1;
            if (s_ff == full_ff) state_in = B_DONE;
            else begin
               s_in = s_ff + 1'b1; j_in = '0; pos_in = '0; acc_in = '0;
               state_in = B_SCAN;
            end
         end
         B_DONE: begin
            // hold until the result register is free
            if (!rv_ff || rsp_tready) begin
               rv_in  = 1'b1;
               ovf_in = ~fits;
               if (fits) det_in = acc_ff[DET_W-1:0];
               else det_in = acc_ff[ACC_W-1] ? {1'b1, {(DET_W-1){1'b0}}}
                                             : {1'b0, {(DET_W-1){1'b1}}};
               state_in = B_LOAD;
            end
         end
         default: state_in = B_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mat_we) mat_mem[pop_entry.addr] <= pop_entry.elem;
      mat_rd_ff <= mat_mem[mat_raddr];
      if (work_we) work_mem[work_waddr] <= work_wdata;
      work_rd_ff <= work_mem[work_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_LOAD;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
      n_ff <= n_in; j_ff <= j_in; pos_ff <= pos_in;
      full_ff <= full_in; s_ff <= s_in;
      acc_ff <= acc_in; prod_ff <= prod_in; neg_ff <= neg_in;
      det_ff <= det_in; ovf_ff <= ovf_in;
   end
endmodule

[hw/rtl/integer_determinant_engine.sv]
`timescale 1ns / 1ps
// Integer determinant engine. Elements arrive one request per cycle, while
// the queue is not full, in row-major order into a four-entry queue; the
// order n (1..8, reset 5) is written on the csr port and restarts the load,
// and requests are held off in the cycle of that write. After the last
// element the back end expands minors over every column subset, one shared
// 8x72 multiply per term, reading partial minors through the single read
// port of the 256-entry minor store. Overflow in tuser saturates tdata.
// Depends on idet_pkg, idet_front, idet_queue and idet_back.
module integer_determinant_engine import idet_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [ORDER_W-1:0]   csr_data,    // matrix_order
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ELEM_W-1:0]    req_tdata,   // element_value
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DET_W-1:0]     rsp_tdata,   // determinant
   output logic                 rsp_tuser    // overflow
);
   logic      push, qfull, pop, pop_valid;
   entry_type push_entry, pop_entry;

   idet_front u_front (
      .clock, .reset, .csr_valid, .csr_ready, .csr_data,
      .req_tvalid, .req_tready, .req_tdata,
      .push, .push_entry, .queue_full(qfull)
   );

   idet_queue u_queue (
      .clock, .reset, .push, .push_entry, .full(qfull),
      .pop, .pop_valid, .pop_entry
   );

   idet_back u_back (
      .clock, .reset, .pop_valid, .pop_entry, .pop,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );
endmodule

[hw/rtl/idet_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the integer determinant engine, bound to the top.
// Depends on idet_pkg.
module idet_checker import idet_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             csr_ready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [DET_W-1:0] rsp_tdata,
   input logic             rsp_tuser
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == {1'b1, {(DET_W-1){1'b0}}}
                               || rsp_tdata == {1'b0, {(DET_W-1){1'b1}}})
      else $error("overflow without saturated determinant");

   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("response valid straight after reset");

   a_csr: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr port stalled");
endmodule

bind integer_determinant_engine idet_checker u_checker (
   .clock, .reset, .csr_ready, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
);

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for integer_determinant_engine: streams matrices
// in row-major order and checks each determinant against a subset-expansion
// predictor or a known value. Depends on idet_pkg and the RTL of the engine.
module testbench;
   import idet_pkg::*;

   typedef enum int {FILL_CONST, FILL_DIAG, FILL_HADAMARD, FILL_RANDOM} fill_kind_type;

   typedef struct {
      int            raw_order;   // value written to the csr port, -1 for no write
      int            prefix;      // elements sent before the write, dropped by it
      fill_kind_type kind;
      int            value;
      bit            known;
      logic [63:0]   det;
      bit            ovf;
   } plan_row_type;

   typedef struct {
      logic [DET_W-1:0] det;
      logic             ovf;
   } det_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [ORDER_W-1:0]   csr_data = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ELEM_W-1:0]    req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DET_W-1:0]     rsp_tdata;
   logic                 rsp_tuser;

   det_result_type       pending_dets[$];
   plan_row_type         plan[$];
   int                   mismatches = 0;
   bit                   quiet = 1'b0;
   int                   rsp_stall = 0;

   // predictor state
   int                   cur_order = 5;
   int                   load_pos = 0;
   logic signed [7:0]    mat[MAX_ORDER][MAX_ORDER];

   integer_determinant_engine u_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("integer_determinant_engine regression: fail");
      $finish;
   end

   // Expand minors over every column subset, row by row, in 128-bit arithmetic.
   function automatic det_result_type det_predict(int n);
      logic signed [127:0] minor[1 << MAX_ORDER];
      logic signed [127:0] hi;
      logic signed [127:0] lo;
      logic signed [127:0] acc;
      det_result_type      r;
      int                  k;
      int                  pos;
      hi = 128'sh7FFF_FFFF_FFFF_FFFF;
      lo = -hi - 128'sd1;
      minor[0] = 128'sd1;
      for (int s = 1; s < (1 << n); s++) begin
         k = $countones(s);
         pos = 0;
         acc = '0;
         for (int j = 0; j < n; j++) begin
            if (s[j]) begin
               if (((k - 1 + pos) & 1) != 0)
                  acc = acc - 128'(mat[k-1][j]) * minor[s & ~(1 << j)];
               else
                  acc = acc + 128'(mat[k-1][j]) * minor[s & ~(1 << j)];
               pos++;
            end
         end
         minor[s] = acc;
      end
      acc = minor[(1 << n) - 1];
      if (acc > hi) begin
         r.det = 64'h7FFF_FFFF_FFFF_FFFF;
         r.ovf = 1'b1;
      end else if (acc < lo) begin
         r.det = 64'h8000_0000_0000_0000;
         r.ovf = 1'b1;
      end else begin
         r.det = acc[63:0];
         r.ovf = 1'b0;
      end
      return r;
   endfunction

   function automatic int latency_of(int n);
      return (1 << n) * (n + 8 + (3 * n) / 2) + 64;
   endfunction

   // Hold until every determinant is back, then let the back end settle.
   task automatic drain();
      while (pending_dets.size() > 0) @(posedge clock);
      repeat (latency_of(cur_order)) @(posedge clock);
   endtask

   task automatic write_order(int raw);
      drain();
      csr_valid <= 1'b1;
      csr_data <= raw[ORDER_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_order = (raw & 15) < 1 ? 1 : ((raw & 15) > MAX_ORDER ? MAX_ORDER : (raw & 15));
      load_pos = 0;
   endtask

   // Send one element; returns 1 when it completed a matrix.
   task automatic send_element(logic [7:0] v, output bit done);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      mat[load_pos / cur_order][load_pos % cur_order] = v;
      load_pos++;
      done = (load_pos == cur_order * cur_order);
      if (done) load_pos = 0;
   endtask

   function automatic logic [7:0] element_for(fill_kind_type kind, int value, int r, int c,
                                              int mode);
      case (kind)
         FILL_CONST:    return value[7:0];
         FILL_DIAG:     return (r == c) ? value[7:0] : 8'd0;
         FILL_HADAMARD: return ($countones(r & c) % 2 != 0) ? 8'(-value) : value[7:0];
         default: begin
            if (mode == 1) return 8'($signed($urandom_range(0, 4)) - 2);
            if (mode == 2 && $urandom_range(0, 3) == 0) return 8'd0;
            return 8'($urandom);
         end
      endcase
   endfunction

   task automatic send_matrix(fill_kind_type kind, int value, bit known, logic [63:0] det,
                              bit ovf, int mode);
      det_result_type r;
      bit             done;
      for (int i = 0; i < cur_order * cur_order; i++) begin
         send_element(element_for(kind, value, i / cur_order, i % cur_order, mode), done);
         if (done) begin
            r = det_predict(cur_order);
            if (known) begin
               r.det = det;
               r.ovf = ovf;
            end
            pending_dets.push_back(r);
         end
      end
   endtask

   // result side: random stalls, compare against the oldest expectation
   always @(posedge clock) begin
      det_result_type e;
      bit             next_ready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_dets.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result det=%h ovf=%b", rsp_tdata, rsp_tuser);
            end else begin
               e = pending_dets.pop_front();
               if (e.det !== rsp_tdata || e.ovf !== rsp_tuser) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected det=%h ovf=%b, got det=%h ovf=%b",
                              e.det, e.ovf, rsp_tdata, rsp_tuser);
               end
            end
         end
         if (quiet) begin
            next_ready = 1'b1;
            rsp_stall = 0;
         end else if (rsp_stall > 0) begin
            next_ready = 1'b0;
            rsp_stall--;
         end else if ($urandom_range(0, 5) == 0) begin
            next_ready = 1'b0;
            rsp_stall = $urandom_range(0, 4);
         end else begin
            next_ready = 1'b1;
         end
         rsp_tready <= next_ready;
      end
   end

   initial begin
      int            sent;
      int            n;
      int            raw;
      int            count;
      bit            done;
      plan_row_type  p;
      // reset order first, then saturating writes, extremes and overflow
      plan.push_back('{-1, 0, FILL_DIAG, 1, 1, 64'd1, 0});
      plan.push_back('{0, 0, FILL_CONST, -128, 1, 64'hFFFF_FFFF_FFFF_FF80, 0});
      plan.push_back('{1, 0, FILL_CONST, 127, 1, 64'd127, 0});
      plan.push_back('{-1, 0, FILL_CONST, 0, 1, 64'd0, 0});
      plan.push_back('{2, 0, FILL_CONST, -128, 1, 64'd0, 0});
      plan.push_back('{-1, 0, FILL_DIAG, 127, 1, 64'd16129, 0});
      plan.push_back('{-1, 0, FILL_RANDOM, 0, 0, 64'd0, 0});
      plan.push_back('{3, 0, FILL_DIAG, -128, 1, 64'hFFFF_FFFF_FFE0_0000, 0});
      plan.push_back('{-1, 0, FILL_RANDOM, 0, 0, 64'd0, 0});
      plan.push_back('{2, 5, FILL_RANDOM, 0, 0, 64'd0, 0});
      plan.push_back('{4, 0, FILL_RANDOM, 0, 0, 64'd0, 0});
      plan.push_back('{15, 0, FILL_DIAG, -1, 1, 64'd1, 0});
      plan.push_back('{-1, 0, FILL_HADAMARD, -128, 0, 64'd0, 0});
      plan.push_back('{8, 0, FILL_HADAMARD, 127, 0, 64'd0, 0});

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         p = plan[i];
         for (int k = 0; k < p.prefix; k++) send_element(8'($urandom), done);
         if (p.raw_order >= 0) begin
            req_tvalid <= 1'b0;
            write_order(p.raw_order);
         end
         send_matrix(p.kind, p.value, p.known, p.det, p.ovf, 0);
      end

      sent = 0;
      while (sent < 1575) begin
         if (sent > 1450) quiet = 1'b1;
         case ($urandom_range(0, 9))
            0:       n = $urandom_range(7, 8);
            1, 2:    n = $urandom_range(5, 6);
            default: n = $urandom_range(1, 4);
         endcase
         raw = n;
         if (n == 1 && $urandom_range(0, 1) == 1) raw = 0;
         if (n == 8) raw = $urandom_range(8, 15);
         req_tvalid <= 1'b0;
         write_order(raw);
         count = (n >= 7) ? $urandom_range(1, 2) : $urandom_range(1, 6);
         for (int m = 0; m < count; m++) begin
            send_matrix(FILL_RANDOM, 0, 0, 64'd0, 0, $urandom_range(0, 2));
            sent += n * n;
         end
      end
      req_tvalid <= 1'b0;
      drain();
      if (mismatches == 0 && pending_dets.size() == 0)
         $display("integer_determinant_engine regression: pass");
      else
         $display("integer_determinant_engine regression: fail");
      $finish;
   end
endmodule

[files.f]
hw/rtl/idet_pkg.sv
hw/rtl/idet_front.sv
hw/rtl/idet_queue.sv
hw/rtl/idet_back.sv
hw/rtl/integer_determinant_engine.sv
hw/rtl/idet_checker.sv
verif/testbench.sv
